FILE: src/gho_pkg.sv
// shared types, constants and tables for the haversine odometer
package gho_pkg;

	localparam int CORDIC_ITERATIONS = 32;
	localparam int TAB_LEN = 48;
	localparam int ANG_W = 46;
	localparam int ITER_W = 6;
	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [ANG_W-1:0] ang_t;
	typedef ang_t atan_tab_t [TAB_LEN];

	localparam logic [63:0] ONE_Q40 = 64'd1 << 40;
	localparam logic [63:0] QUARTER_PI_Q40 = 64'd863554413088;
	localparam logic [63:0] HALF_PI_Q40 = 64'd1727108826176;
	localparam logic [63:0] PI_Q40 = 64'd3454217652352;
	localparam logic [39:0] GAIN_INV_Q40 = 40'd667681663044;
	localparam logic [30:0] DEG7_TO_RAD = 31'd2012227627;
	localparam logic [30:0] TWO_RADIUS_CM = 31'd1274200000;
	localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
	localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;
	localparam ang_t ONE_ANG = ang_t'(ONE_Q40);

	// register map, index is paddr[4:2]
	localparam logic [2:0] REG_BOX_LAT_LOW = 3'd0;
	localparam logic [2:0] REG_BOX_LAT_HIGH = 3'd1;
	localparam logic [2:0] REG_BOX_LON_LOW = 3'd2;
	localparam logic [2:0] REG_BOX_LON_HIGH = 3'd3;
	localparam logic [2:0] REG_TARGET = 3'd4;

	typedef struct packed {
		logic signed [30:0] box_lat_low;
		logic signed [30:0] box_lat_high;
		logic signed [31:0] box_lon_low;
		logic signed [31:0] box_lon_high;
		logic [31:0] target_distance;
	} cfg_t;

	typedef struct packed {
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic inbox;
	} job_t;

	typedef struct packed {
		logic [30:0] step_distance;
		logic [31:0] total_distance;
		logic tracking;
		logic arrived;
	} res_t;

	// atan(2^-i) in q40, series summed in q62 then rounded
	function automatic atan_tab_t build_atan();
		atan_tab_t tab;
		logic [63:0] sum;
		logic [63:0] term;
		int sh;
		tab[0] = ang_t'(QUARTER_PI_Q40);
		for (int i = 1; i < TAB_LEN; i++) begin
			sum = '0;
			for (int k = 0; k < 32; k++) begin
				sh = i * (2 * k + 1);
				if (sh <= 62) begin
					term = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
					if (k % 2 == 1)
						sum = sum - term;
					else
						sum = sum + term;
				end
			end
			tab[i] = ang_t'((sum + 64'd2097152) >> 22);
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

	function automatic logic [40:0] clamp_q40(input ang_t v);
		if (v < 0)
			return '0;
		else if (v > ONE_ANG)
			return 41'(ONE_Q40);
		else
			return v[40:0];
	endfunction

endpackage

FILE: src/gho_cfg.sv
// apb configuration registers
module gho_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output gho_pkg::cfg_t     cfg
);

	gho_pkg::cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_lat_low <= 31'sd300638560;
			cfg_q.box_lat_high <= 31'sd300639400;
			cfg_q.box_lon_low <= 32'sd312775410;
			cfg_q.box_lon_high <= 32'sd312776530;
			cfg_q.target_distance <= 32'd10000;
		end else if (wr_en) begin
			case (idx)
				gho_pkg::REG_BOX_LAT_LOW: cfg_q.box_lat_low <= pwdata[30:0];
				gho_pkg::REG_BOX_LAT_HIGH: cfg_q.box_lat_high <= pwdata[30:0];
				gho_pkg::REG_BOX_LON_LOW: cfg_q.box_lon_low <= pwdata;
				gho_pkg::REG_BOX_LON_HIGH: cfg_q.box_lon_high <= pwdata;
				gho_pkg::REG_TARGET: cfg_q.target_distance <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			gho_pkg::REG_BOX_LAT_LOW: prdata = {1'b0, cfg_q.box_lat_low};
			gho_pkg::REG_BOX_LAT_HIGH: prdata = {1'b0, cfg_q.box_lat_high};
			gho_pkg::REG_BOX_LON_LOW: prdata = cfg_q.box_lon_low;
			gho_pkg::REG_BOX_LON_HIGH: prdata = cfg_q.box_lon_high;
			gho_pkg::REG_TARGET: prdata = cfg_q.target_distance;
			default: prdata = '0;
		endcase
	end

endmodule

FILE: src/gho_front.sv
// front end: takes fixes, classifies against the start box, queues jobs
module gho_front (
	input  logic               clk,
	input  logic               arst_n,
	input  gho_pkg::cfg_t      cfg,
	input  logic               push,
	output logic               full,
	input  logic signed [30:0] fix_lat,
	input  logic signed [31:0] fix_lon,
	output logic               job_valid,
	output gho_pkg::job_t      job,
	input  logic               job_pop
);

	gho_pkg::job_t mem_q [gho_pkg::QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic wr_en;
	logic rd_en;
	gho_pkg::job_t wr_job;

	assign full = (cnt_q == 2'(gho_pkg::QUEUE_DEPTH));
	assign job_valid = (cnt_q != 2'd0);
	assign job = mem_q[rd_ptr_q];
	assign wr_en = push & ~full;
	assign rd_en = job_pop & job_valid;

	always_comb begin
		wr_job.lat = fix_lat;
		wr_job.lon = fix_lon;
		// strictly inside the box on both axes
		wr_job.inbox = (fix_lat > cfg.box_lat_low) && (fix_lat < cfg.box_lat_high) &&
			(fix_lon > cfg.box_lon_low) && (fix_lon < cfg.box_lon_high);
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 2'd1;
			else if (!wr_en && rd_en)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

FILE: src/gho_back.sv
// back end: trip state, cordic/sqrt/multiply sequencer and result queue
module gho_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    target_distance,
	input  logic           job_valid,
	input  gho_pkg::job_t  job,
	output logic           job_pop,
	output logic           res_empty,
	input  logic           res_pop,
	output gho_pkg::res_t  res
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIFF, ST_ANG_MUL, ST_ANG_LOAD, ST_CORD, ST_CORD_END,
		ST_CMUL, ST_SQ_INIT, ST_SQRT, ST_SQ_END, ST_MH, ST_ML, ST_MS,
		ST_D1, ST_D2, ST_D3, ST_FIN
	} st_t;

	typedef enum logic [3:0] {
		LEG_S1, LEG_S2, LEG_C1, LEG_C2, LEG_Q, LEG_T, LEG_M, LEG_H, LEG_A2,
		LEG_G, LEG_HALF
	} leg_t;

	localparam logic [gho_pkg::ITER_W-1:0] ITER_LAST =
		gho_pkg::ITER_W'(gho_pkg::CORDIC_ITERATIONS - 1);
	localparam logic [gho_pkg::ITER_W-1:0] SQRT_LAST = gho_pkg::ITER_W'(31);

	st_t state_q;
	leg_t leg_q;
	logic mode_q;
	logic signed [30:0] prev_lat_q;
	logic signed [31:0] prev_lon_q;
	logic [31:0] sum_q;

	logic signed [30:0] cur_lat_q, l1_q, l2_q;
	logic signed [31:0] cur_lon_q, o1_q, o2_q;
	logic [31:0] m_dlat_q, m_dlon_q, m_l1_q, m_l2_q;
	logic [40:0] s1_q, s2_q, c1_q, c2_q, h_q;
	logic [41:0] ma_q;
	logic [40:0] mb_q;
	logic [63:0] prod_q, hi_q;
	logic [44:0] half_q;
	logic [30:0] dist_q;

	gho_pkg::ang_t cx_q, cy_q, cz_q;
	logic rot_q;
	logic [gho_pkg::ITER_W-1:0] it_q;
	logic [63:0] sq_v_q, sq_r_q, sq_b_q;

	logic [41:0] mul_a;
	logic [30:0] mul_b;
	logic [72:0] prod_w;

	gho_pkg::ang_t dx, dy, atan_i;
	logic pos;
	logic [63:0] sq_rb, zf, mres;
	logic [32:0] nsum;
	logic [31:0] sat_sum;
	logic room;
	logic start;
	logic signed [31:0] dlat;
	logic signed [32:0] dlon;

	// result queue
	gho_pkg::res_t rmem_q [gho_pkg::QUEUE_DEPTH];
	logic rwr_q, rrd_q;
	logic [1:0] rcnt_q;
	logic res_push;
	gho_pkg::res_t res_in;
	logic res_rd;

	function automatic logic signed [30:0] gho_clamp_lat(input logic signed [30:0] v);
		if (v > gho_pkg::LAT_LIMIT)
			return gho_pkg::LAT_LIMIT;
		else if (v < -gho_pkg::LAT_LIMIT)
			return -gho_pkg::LAT_LIMIT;
		else
			return v;
	endfunction

	function automatic logic signed [31:0] gho_clamp_lon(input logic signed [31:0] v);
		if (v > gho_pkg::LON_LIMIT)
			return gho_pkg::LON_LIMIT;
		else if (v < -gho_pkg::LON_LIMIT)
			return -gho_pkg::LON_LIMIT;
		else
			return v;
	endfunction

	assign room = (rcnt_q != 2'(gho_pkg::QUEUE_DEPTH));
	assign start = (state_q == ST_IDLE) && job_valid && room;
	assign job_pop = start;
	assign res_empty = (rcnt_q == 2'd0);
	assign res = rmem_q[rrd_q];
	assign res_rd = res_pop & ~res_empty;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ANG_MUL: begin
				case (leg_q)
					LEG_S1: mul_a = {10'b0, m_dlat_q};
					LEG_S2: mul_a = {10'b0, m_dlon_q};
					LEG_C1: mul_a = {10'b0, m_l1_q};
					default: mul_a = {10'b0, m_l2_q};
				endcase
				mul_b = gho_pkg::DEG7_TO_RAD;
			end
			ST_CMUL: begin
				mul_a = {11'b0, c1_q[40:10]};
				mul_b = c2_q[40:10];
			end
			ST_MH: begin
				mul_a = ma_q;
				mul_b = {10'b0, mb_q[40:20]};
			end
			ST_ML: begin
				mul_a = ma_q;
				mul_b = {11'b0, mb_q[19:0]};
			end
			ST_D1: begin
				mul_a = {17'b0, half_q[44:20]};
				mul_b = gho_pkg::TWO_RADIUS_CM;
			end
			ST_D2: begin
				mul_a = {22'b0, half_q[19:0]};
				mul_b = gho_pkg::TWO_RADIUS_CM;
			end
			default: ;
		endcase
	end

	assign prod_w = 73'(mul_a) * 73'(mul_b);

	always_comb begin
		dx = cy_q >>> it_q;
		dy = cx_q >>> it_q;
		atan_i = gho_pkg::ATAN_TAB[it_q];
		pos = rot_q ? (cz_q < 0) : (cy_q >= 0);
		sq_rb = sq_r_q + sq_b_q;
		if (leg_q == LEG_S1 || leg_q == LEG_S2)
			zf = (prod_q + 64'd1048576) >> 21;
		else
			zf = (prod_q + 64'd524288) >> 20;
		if (leg_q == LEG_S2 && zf > gho_pkg::HALF_PI_Q40)
			zf = gho_pkg::PI_Q40 - zf;
		mres = (hi_q + (prod_q >> 20)) >> 20;
		nsum = {1'b0, sum_q} + {2'b0, dist_q};
		sat_sum = nsum[32] ? 32'hFFFF_FFFF : nsum[31:0];
		dlat = {l2_q[30], l2_q} - {l1_q[30], l1_q};
		dlon = {o2_q[31], o2_q} - {o1_q[31], o1_q};
	end

	always_comb begin
		res_push = 1'b0;
		res_in = '0;
		if (start && !mode_q) begin
			res_push = 1'b1;
			res_in.step_distance = '0;
			res_in.total_distance = job.inbox ? 32'd0 : sum_q;
			res_in.tracking = job.inbox;
			res_in.arrived = 1'b0;
		end else if (state_q == ST_FIN) begin
			res_push = 1'b1;
			res_in.step_distance = dist_q;
			res_in.total_distance = sat_sum;
			res_in.tracking = ~(sat_sum > target_distance);
			res_in.arrived = sat_sum > target_distance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			leg_q <= LEG_S1;
			mode_q <= 1'b0;
			prev_lat_q <= '0;
			prev_lon_q <= '0;
			sum_q <= '0;
			rot_q <= 1'b0;
			it_q <= '0;
		end else begin
			prod_q <= prod_w[63:0];
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (!mode_q) begin
							if (job.inbox) begin
								prev_lat_q <= job.lat;
								prev_lon_q <= job.lon;
								sum_q <= '0;
								mode_q <= 1'b1;
							end
						end else begin
							cur_lat_q <= job.lat;
							cur_lon_q <= job.lon;
							l1_q <= gho_clamp_lat(prev_lat_q);
							l2_q <= gho_clamp_lat(job.lat);
							o1_q <= gho_clamp_lon(prev_lon_q);
							o2_q <= gho_clamp_lon(job.lon);
							if (job.lat == prev_lat_q && job.lon == prev_lon_q) begin
								dist_q <= '0;
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_DIFF;
							end
						end
					end
				end
				ST_DIFF: begin
					m_dlat_q <= dlat[31] ? -dlat : dlat;
					m_dlon_q <= dlon[32] ? 32'(-dlon) : dlon[31:0];
					m_l1_q <= {1'b0, (l1_q[30] ? -l1_q : l1_q)};
					m_l2_q <= {1'b0, (l2_q[30] ? -l2_q : l2_q)};
					leg_q <= LEG_S1;
					state_q <= ST_ANG_MUL;
				end
				ST_ANG_MUL: state_q <= ST_ANG_LOAD;
				ST_ANG_LOAD: begin
					cx_q <= gho_pkg::ang_t'(gho_pkg::GAIN_INV_Q40);
					cy_q <= '0;
					cz_q <= $signed(zf[gho_pkg::ANG_W-1:0]);
					rot_q <= 1'b1;
					it_q <= '0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (pos) begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						cz_q <= cz_q + atan_i;
					end else begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						cz_q <= cz_q - atan_i;
					end
					it_q <= it_q + 1'b1;
					if (it_q == ITER_LAST)
						state_q <= ST_CORD_END;
				end
				ST_CORD_END: begin
					case (leg_q)
						LEG_S1: begin
							s1_q <= gho_pkg::clamp_q40(cy_q);
							leg_q <= LEG_S2;
							state_q <= ST_ANG_MUL;
						end
						LEG_S2: begin
							s2_q <= gho_pkg::clamp_q40(cy_q);
							leg_q <= LEG_C1;
							state_q <= ST_ANG_MUL;
						end
						LEG_C1: begin
							c1_q <= gho_pkg::clamp_q40(cx_q);
							leg_q <= LEG_C2;
							state_q <= ST_ANG_MUL;
						end
						LEG_C2: begin
							c2_q <= gho_pkg::clamp_q40(cx_q);
							leg_q <= LEG_Q;
							state_q <= ST_CMUL;
						end
						LEG_M: begin
							ma_q <= (cx_q < 0) ? 42'd0 : cx_q[41:0];
							mb_q <= {1'b0, gho_pkg::GAIN_INV_Q40};
							leg_q <= LEG_H;
							state_q <= ST_MH;
						end
						default: begin
							half_q <= (cz_q < 0) ? 45'd0 : cz_q[44:0];
							state_q <= ST_D1;
						end
					endcase
				end
				ST_CMUL: state_q <= ST_SQ_INIT;
				ST_SQ_INIT: begin
					sq_v_q <= prod_q;
					sq_r_q <= '0;
					sq_b_q <= 64'd1 << 62;
					it_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_v_q >= sq_rb) begin
						sq_v_q <= sq_v_q - sq_rb;
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q <= sq_b_q >> 2;
					it_q <= it_q + 1'b1;
					if (it_q == SQRT_LAST)
						state_q <= ST_SQ_END;
				end
				ST_SQ_END: begin
					if (leg_q == LEG_Q) begin
						ma_q <= {1'b0, s2_q};
						mb_q <= {sq_r_q[30:0], 10'b0};
						leg_q <= LEG_T;
						state_q <= ST_MH;
					end else begin
						cx_q <= gho_pkg::ang_t'({sq_r_q[34:0], 10'b0});
						cy_q <= gho_pkg::ang_t'(h_q);
						cz_q <= '0;
						rot_q <= 1'b0;
						it_q <= '0;
						leg_q <= LEG_HALF;
						state_q <= ST_CORD;
					end
				end
				ST_MH: state_q <= ST_ML;
				ST_ML: begin
					hi_q <= prod_q;
					state_q <= ST_MS;
				end
				ST_MS: begin
					case (leg_q)
						LEG_T: begin
							cx_q <= gho_pkg::ang_t'(s1_q);
							cy_q <= gho_pkg::ang_t'(mres);
							cz_q <= '0;
							rot_q <= 1'b0;
							it_q <= '0;
							leg_q <= LEG_M;
							state_q <= ST_CORD;
						end
						LEG_H: begin
							h_q <= (mres > gho_pkg::ONE_Q40) ? 41'(gho_pkg::ONE_Q40) : mres[40:0];
							ma_q <= (mres > gho_pkg::ONE_Q40) ? 42'(gho_pkg::ONE_Q40) :
								{1'b0, mres[40:0]};
							mb_q <= (mres > gho_pkg::ONE_Q40) ? 41'(gho_pkg::ONE_Q40) : mres[40:0];
							leg_q <= LEG_A2;
							state_q <= ST_MH;
						end
						default: begin
							sq_v_q <= (gho_pkg::ONE_Q40 -
								((mres > gho_pkg::ONE_Q40) ? gho_pkg::ONE_Q40 : mres)) << 20;
							sq_r_q <= '0;
							sq_b_q <= 64'd1 << 62;
							it_q <= '0;
							leg_q <= LEG_G;
							state_q <= ST_SQRT;
						end
					endcase
				end
				ST_D1: state_q <= ST_D2;
				ST_D2: begin
					hi_q <= prod_q;
					state_q <= ST_D3;
				end
				ST_D3: begin
					if (((hi_q + (prod_q >> 20) + 64'd524288) >> 20) > 64'h7FFF_FFFF)
						dist_q <= 31'h7FFF_FFFF;
					else
						dist_q <= 31'((hi_q + (prod_q >> 20) + 64'd524288) >> 20);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					sum_q <= sat_sum;
					prev_lat_q <= cur_lat_q;
					prev_lon_q <= cur_lon_q;
					if (sat_sum > target_distance)
						mode_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			rmem_q[rwr_q] <= res_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q <= 1'b0;
			rrd_q <= 1'b0;
			rcnt_q <= 2'd0;
		end else begin
			if (res_push)
				rwr_q <= ~rwr_q;
			if (res_rd)
				rrd_q <= ~rrd_q;
			if (res_push && !res_rd)
				rcnt_q <= rcnt_q + 2'd1;
			else if (!res_push && res_rd)
				rcnt_q <= rcnt_q - 2'd1;
		end
	end

endmodule

FILE: src/gps_haversine_odometer.sv
// top level of the gps haversine odometer
// Takes one GPS fix per item (latitude and longitude in 1e-7 degree) and returns
// one result item per fix. While idle, a fix strictly inside the start box starts
// a trip: the total is cleared and tracking goes high. While tracking, each fix
// gives its great-circle distance in centimetres from the previous fix (earth
// radius 6371 km), added to a total that saturates at 2^32-1; once the total
// exceeds target_distance the item carries arrived and the block goes idle.
// An item that needs no distance (idle, or a fix identical to the previous point)
// skips the distance sequence. A distance takes four rotation runs and two
// vectoring runs of one shared CORDIC stage, two 32-step square roots and the
// multiplies on one shared multiplier, all on one sequencer, which takes no new
// fix until it is done with the last. A two-entry queue sits in front of the
// sequencer and another behind it, so push is taken while a result still waits.
// Configuration is to be written over the APB port only while no item is in
// flight; the block itself does not enforce this.
module gps_haversine_odometer (
	input  logic               clk,
	input  logic               arst_n,
	// fix input queue side
	input  logic               push,
	output logic               full,
	input  logic signed [30:0] fix_lat,
	input  logic signed [31:0] fix_lon,
	// result queue side
	output logic               empty,
	input  logic               pop,
	output logic [30:0]        step_distance,
	output logic [31:0]        total_distance,
	output logic               tracking,
	output logic               arrived,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	gho_pkg::cfg_t cfg;
	gho_pkg::job_t job;
	gho_pkg::res_t res;
	logic job_valid;
	logic job_pop;

	// register file, box bounds and trip target
	gho_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front end: box test at entry, job queue
	gho_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.fix_lat   (fix_lat),
		.fix_lon   (fix_lon),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	// back end: trip state, distance sequencer, result queue
	gho_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.target_distance (cfg.target_distance),
		.job_valid       (job_valid),
		.job             (job),
		.job_pop         (job_pop),
		.res_empty       (empty),
		.res_pop         (pop),
		.res             (res)
	);

	// result fields straight off the head of the result queue
	assign step_distance = res.step_distance;
	assign total_distance = res.total_distance;
	assign tracking = res.tracking;
	assign arrived = res.arrived;

endmodule
